[hdl/dncd_pkg.sv]
// shared types, constants and helper functions for the day number to date pipeline
// no dependencies
package dncd_pkg;

    // valid input range, both bounds lie outside it
    localparam logic [21:0] C_DN_LOW  = 22'd365;
    localparam logic [21:0] C_DN_HIGH = 22'd3652500;

    // year estimate: floor(4*dn/1461) through a floor reciprocal and one correction
    localparam int          C_YEAR_SHIFT = 35;
    localparam logic [24:0] C_YEAR_MUL   = 25'd23517959;
    localparam logic [10:0] C_DAYS_4Y    = 11'd1461;

    // n/100 = (n*5243) >> 19, exact for every 14-bit year
    localparam int          C_DIV100_SHIFT = 19;
    localparam logic [12:0] C_DIV100_MUL   = 13'd5243;

    localparam logic [8:0] C_DAYS_YEAR = 9'd365;
    localparam logic [8:0] C_DAYS_LEAP = 9'd366;
    localparam logic [8:0] C_JAN_FEB   = 9'd59;

    // days before the first of each month in a common year
    localparam logic [8:0] C_MONTH_CUM [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef logic signed [23:0] t_doy;

    // year and day of year travelling between stages
    typedef struct packed {
        logic       valid;
        logic       blank;
        logic [13:0] year;
        logic [7:0]  cent;
        logic [6:0]  rem;
        logic [1:0]  yoff;
        t_doy        doy;
    } t_ydoy;

    // gregorian leap test of (cent*100 + rem + k) for small k
    function automatic logic f_leap(input logic [7:0] cent, input logic [6:0] rem,
                                    input logic [1:0] k);
        logic [7:0] s;
        logic [7:0] rn;
        logic [7:0] cn;
        s = {1'b0, rem} + {6'd0, k};
        if (s >= 8'd100) begin
            rn = s - 8'd100;
            cn = cent + 8'd1;
        end else begin
            rn = s;
            cn = cent;
        end
        return (rn == 8'd0) ? (cn[1:0] == 2'b00) : (rn[1:0] == 2'b00);
    endfunction

    // widen a day count to the signed day-of-year width
    function automatic t_doy f_wide(input logic [8:0] d);
        return $signed({15'd0, d});
    endfunction

    // stage word with its valid bit cleared while reset is low
    function automatic t_ydoy f_gate_valid(input t_ydoy a, input logic rst_n);
        t_ydoy b;
        b       = a;
        b.valid = a.valid & rst_n;
        return b;
    endfunction

endpackage

[hdl/dncd_year_est.sv]
// year estimate and day of year with century correction, four register stages
// depends on dncd_pkg
module dncd_year_est
    import dncd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [21:0] i_day_number,
    output t_ydoy       o_ydoy
);

    logic        r_s1_valid, r_s2_valid, r_s3_valid;
    logic        r_s1_blank, r_s2_blank, r_s3_blank;
    logic [23:0] r_s1_x;
    logic [13:0] r_s1_q;
    logic [21:0] r_s2_dn, r_s3_dn;
    logic [13:0] r_s2_year, r_s3_year;
    logic [7:0]  r_s3_c100, r_s3_cent;
    t_ydoy       r_s4;

    logic [23:0] n_s1_x;
    logic [48:0] n_s1_prod;
    logic        n_s1_blank;
    logic [24:0] n_s2_rem;
    logic [13:0] n_s2_year;
    logic [13:0] n_s3_ym1;
    logic [26:0] n_s3_c100p, n_s3_centp;
    logic [13:0] n_s4_ym1;
    logic [10:0] n_s4_corr3;
    logic [23:0] n_s4_doy;
    logic [14:0] n_s4_rem;
    t_ydoy       n_s4;

    // stage 1: reciprocal multiply for 4*dn/1461
    always_comb begin
        n_s1_x     = {i_day_number, 2'b00};
        n_s1_prod  = 49'(n_s1_x) * 49'(C_YEAR_MUL);
        n_s1_blank = (i_day_number <= C_DN_LOW) || (i_day_number >= C_DN_HIGH);
    end

    // stage 2: remainder check fixes an estimate that is one low
    always_comb begin
        n_s2_rem  = 25'(r_s1_x) - 25'(r_s1_q) * 25'(C_DAYS_4Y);
        n_s2_year = r_s1_q + 14'(n_s2_rem >= 25'(C_DAYS_4Y));
    end

    // stage 3: centuries of year-1 and of year
    always_comb begin
        n_s3_ym1   = r_s2_year - 14'd1;
        n_s3_c100p = 27'(n_s3_ym1) * 27'(C_DIV100_MUL);
        n_s3_centp = 27'(r_s2_year) * 27'(C_DIV100_MUL);
    end

    // stage 4: day of year and the year's offset within its century
    always_comb begin
        n_s4_ym1   = r_s3_year - 14'd1;
        n_s4_corr3 = (11'(r_s3_c100) + 11'd1) * 11'd3;
        n_s4_doy   = 24'(r_s3_dn) - 24'(r_s3_year) * 24'(C_DAYS_YEAR)
                   - 24'(n_s4_ym1[13:2]) + 24'(n_s4_corr3[10:2]);
        n_s4_rem   = 15'(r_s3_year) - 15'(r_s3_cent) * 15'd100;
        n_s4.valid = r_s3_valid;
        n_s4.blank = r_s3_blank;
        n_s4.year  = r_s3_year;
        n_s4.cent  = r_s3_cent;
        n_s4.rem   = n_s4_rem[6:0];
        n_s4.yoff  = 2'd0;
        n_s4.doy   = $signed(n_s4_doy);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_x     <= n_s1_x;
        r_s1_q     <= n_s1_prod[C_YEAR_SHIFT +: 14];
        r_s1_blank <= n_s1_blank;
        r_s2_dn    <= r_s1_x[23:2];
        r_s2_year  <= n_s2_year;
        r_s2_blank <= r_s1_blank;
        r_s3_dn    <= r_s2_dn;
        r_s3_year  <= r_s2_year;
        r_s3_blank <= r_s2_blank;
        r_s3_c100  <= n_s3_c100p[C_DIV100_SHIFT +: 8];
        r_s3_cent  <= n_s3_centp[C_DIV100_SHIFT +: 8];
    end

    // stage 4 register, only the valid bit is reset
    always_ff @(posedge i_clk) begin
        r_s4 <= f_gate_valid(n_s4, i_rst_n);
    end

    assign o_ydoy = r_s4;

endmodule

[hdl/dncd_year_fix.sv]
// two register stages that step the year forward while the day of year overruns it
// depends on dncd_pkg
module dncd_year_fix
    import dncd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ydoy i_ydoy,
    output t_ydoy o_ydoy
);

    t_ydoy r_s5, r_s6;
    t_ydoy n_s5, n_s6;

    // one forward step: subtract this year's length when the day overruns it
    function automatic t_ydoy f_fix(input t_ydoy a);
        t_ydoy      b;
        logic [8:0] ylen;
        b    = a;
        ylen = f_leap(a.cent, a.rem, a.yoff) ? C_DAYS_LEAP : C_DAYS_YEAR;
        if (a.doy > f_wide(ylen)) begin
            b.doy  = a.doy - f_wide(ylen);
            b.year = a.year + 14'd1;
            b.yoff = a.yoff + 2'd1;
        end
        return b;
    endfunction

    always_comb begin
        n_s5 = f_fix(i_ydoy);
        n_s6 = f_fix(r_s5);
    end

    // stage registers, valid bits reset
    always_ff @(posedge i_clk) begin
        r_s5 <= f_gate_valid(n_s5, i_rst_n);
        r_s6 <= f_gate_valid(n_s6, i_rst_n);
    end

    assign o_ydoy = r_s6;

endmodule

[hdl/dncd_month.sv]
// leap day fold and month lookup, two register stages ending in the result registers
// depends on dncd_pkg
module dncd_month
    import dncd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ydoy       i_ydoy,
    output logic        o_valid,
    output logic [13:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day
);

    logic        r_s7_valid, r_s7_blank, r_s7_leapday;
    logic [13:0] r_s7_year;
    t_doy        r_s7_doy;
    logic        r_valid;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    logic        n_s7_leap, n_s7_leapday;
    t_doy        n_s7_doy;
    logic [3:0]  n_month;
    t_doy        n_dfull;

    // stage 7: take out 29 february in a leap year
    always_comb begin
        n_s7_leap    = f_leap(i_ydoy.cent, i_ydoy.rem, i_ydoy.yoff);
        n_s7_doy     = i_ydoy.doy;
        n_s7_leapday = 1'b0;
        if (n_s7_leap && (i_ydoy.doy > f_wide(C_JAN_FEB))) begin
            n_s7_doy     = i_ydoy.doy - 24'sd1;
            n_s7_leapday = (n_s7_doy == f_wide(C_JAN_FEB));
        end
    end

    // stage 8: month from the cumulative month starts, then day of month
    always_comb begin
        n_month = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (r_s7_doy > f_wide(C_MONTH_CUM[k])) begin
                n_month = n_month + 4'd1;
            end
        end
        n_dfull = r_s7_doy - f_wide(C_MONTH_CUM[n_month - 4'd1])
                + $signed({23'd0, r_s7_leapday});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s7_valid <= i_ydoy.valid;
            r_valid    <= r_s7_valid;
        end
    end

    // payload, out-of-range requests give all zero
    always_ff @(posedge i_clk) begin
        r_s7_blank   <= i_ydoy.blank;
        r_s7_year    <= i_ydoy.year;
        r_s7_doy     <= n_s7_doy;
        r_s7_leapday <= n_s7_leapday;
        if (r_s7_blank) begin
            r_year  <= 14'd0;
            r_month <= 4'd0;
            r_day   <= 5'd0;
        end else begin
            r_year  <= r_s7_year;
            r_month <= n_month;
            r_day   <= n_dfull[4:0];
        end
    end

    assign o_valid = r_valid;
    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

[hdl/day_number_to_calendar_date.sv]
// top level: day number to gregorian year, month and day; uses dncd_pkg and the three stage groups
// path: a request passes stages s1 to s4, s5, s6, s7 and the result registers before its result strobe
// throughput: one request per cycle, set by the eight-stage pipeline; busy never rises
// reset: synchronous active low, clears only the valid bits of the pipeline
// results are strobed for one cycle, the receiver cannot stall
module day_number_to_calendar_date
    import dncd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [21:0] i_day_number,
    output logic        o_valid,
    output logic [13:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day
);

    t_ydoy w_est, w_fix;

    // a new request may enter every cycle
    assign busy = 1'b0;

    // year estimate and day of year
    dncd_year_est u_est (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_day_number (i_day_number),
        .o_ydoy       (w_est)
    );

    // year correction steps
    dncd_year_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ydoy  (w_est),
        .o_ydoy  (w_fix)
    );

    // month and day
    dncd_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ydoy  (w_fix),
        .o_valid (o_valid),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    // every result strobe traces back to an earlier request on start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 8))
        else $error("result strobe without a request eight cycles before");

    // a zero month comes only with a zero date
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month == 4'd0)) |-> ((o_year == 14'd0) && (o_day == 5'd0)))
        else $error("partial zero date");

    // an in-range date has a real year and month
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month != 4'd0)) |-> ((o_year != 14'd0) && (o_month <= 4'd12)))
        else $error("in-range date with bad year or month");

endmodule
